// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every rising clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// expression that must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== src/ufr_pkg.sv =====
`timescale 1ns / 1ps

package ufr_pkg;

    // frame geometry
    localparam int BODY_LEN = 96;
    localparam int POS_W    = 7;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_SYNC1 = t_pos'(0);
    localparam t_pos POS_SYNC2 = t_pos'(1);
    localparam t_pos POS_BODY0 = t_pos'(2);
    localparam t_pos POS_CKA   = t_pos'(BODY_LEN + 2);
    localparam t_pos POS_CKB   = t_pos'(BODY_LEN + 3);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h62;

    // parser state carried from byte to byte
    typedef struct packed {
        t_pos       pos;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
    } t_parse_state;

    // one result word
    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_index;
        logic [7:0] body_byte;
        logic       frame_end;
        logic       frame_ok;
    } t_result;

endpackage

// ===== src/ufr_rx_if.sv =====
`timescale 1ns / 1ps

interface ufr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/ufr_res_if.sv =====
`timescale 1ns / 1ps

interface ufr_res_if;
    logic       valid;
    logic       ready;
    logic       body_valid;
    logic [7:0] body_index;
    logic [7:0] body_byte;
    logic       frame_end;
    logic       frame_ok;

    modport source (
        output valid, output body_valid, output body_index, output body_byte,
        output frame_end, output frame_ok, input ready
    );
    modport sink (
        input valid, input body_valid, input body_index, input body_byte,
        input frame_end, input frame_ok, output ready
    );
endinterface

// ===== src/ufr_step.sv =====
`timescale 1ns / 1ps

module ufr_step
    import ufr_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    input  logic [7:0]   i_sync_first,
    input  logic [7:0]   i_sync_second,
    output t_parse_state o_state,
    output t_result      o_result
);

    t_pos       pos_eff;
    logic [7:0] sum_a_add;
    logic [7:0] sum_b_add;

    // a position past the check b slot behaves as hunting
    assign pos_eff = (i_state.pos > POS_CKB) ? POS_SYNC1 : i_state.pos;

    // fletcher running sums for a body byte
    assign sum_a_add = i_state.sum_a + i_byte;
    assign sum_b_add = i_state.sum_b + sum_a_add;

    // frame tracking and result word
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (pos_eff == POS_SYNC1) begin
            o_state.pos = (i_byte == i_sync_first) ? POS_SYNC2 : POS_SYNC1;
        end else if (pos_eff == POS_SYNC2) begin
            if (i_byte == i_sync_second) begin
                o_state.sum_a = '0;
                o_state.sum_b = '0;
                o_state.pos   = POS_BODY0;
            end else begin
                o_state.pos = POS_SYNC1;
            end
        end else if (pos_eff < POS_CKA) begin
            o_result.body_valid = 1'b1;
            o_result.body_index = 8'({1'b0, pos_eff} - {1'b0, POS_BODY0});
            o_result.body_byte  = i_byte;
            o_state.sum_a       = sum_a_add;
            o_state.sum_b       = sum_b_add;
            o_state.pos         = pos_eff + t_pos'(1);
        end else if (pos_eff == POS_CKA) begin
            if (i_byte != i_state.sum_a) begin
                o_result.frame_end = 1'b1;
                o_state.pos        = POS_SYNC1;
            end else begin
                o_state.pos = POS_CKB;
            end
        end else begin
            o_result.frame_end = 1'b1;
            o_result.frame_ok  = (i_byte == i_state.sum_b);
            o_state.pos        = POS_SYNC1;
        end
    end

endmodule

// ===== src/ubx_frame_receiver.sv =====
`timescale 1ns / 1ps

// Receives serial bytes, one byte per word on i_rx_if, and gives exactly one
// result word per byte on o_res_if: body bytes with their index, and a
// frame-end word with the checksum verdict after a failing first or a second
// check byte. It takes one byte every clock cycle unless the output stalls,
// as the position counter and the two 8-bit running sums update per byte; a
// byte is registered on entry and its result in the result register, and a
// stalled output still lets one more byte into the input register. The user
// must set the preamble bytes via the write port (index 0 first sync byte,
// index 1 second) only while no byte is in flight, unenforced by the block.
`include "assert_macros.svh"

module ubx_frame_receiver
    import ufr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ufr_rx_if.sink                i_rx_if,
    ufr_res_if.source             o_res_if
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_out_valid;
    t_result      r_out;
    t_parse_state r_state;
    logic [7:0]   r_sync_first;
    logic [7:0]   r_sync_second;

    t_parse_state n_state;
    t_result      n_out;
    logic         advance;
    logic         in_ready;

    // handshake: result register frees when empty or taken
    assign advance  = !r_out_valid || o_res_if.ready;
    assign in_ready = !r_in_valid || advance;
    assign i_rx_if.ready = in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_rx_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_rx_if.valid) begin
            r_in_byte <= i_rx_if.rx_byte;
        end
    end

    // per-byte parse step
    ufr_step u_step (
        .i_state       (r_state),
        .i_byte        (r_in_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_state       (n_state),
        .o_result      (n_out)
    );

    // parser state, updated as a byte moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // output word
    assign o_res_if.valid      = r_out_valid;
    assign o_res_if.body_valid = r_out.body_valid;
    assign o_res_if.body_index = r_out.body_index;
    assign o_res_if.body_byte  = r_out.body_byte;
    assign o_res_if.frame_end  = r_out.frame_end;
    assign o_res_if.frame_ok   = r_out.frame_ok;

    // checks on the parser
    `ASSERT_NEVER(a_pos_range, i_clk, i_rst_n, r_state.pos > POS_CKB)
    `ASSERT_NEVER(a_body_and_end, i_clk, i_rst_n, r_out_valid && r_out.body_valid && r_out.frame_end)
    `ASSERT_PROP(a_ok_needs_end, i_clk, i_rst_n, (r_out_valid && r_out.frame_ok) |-> r_out.frame_end)
    `ASSERT_PROP(a_index_range, i_clk, i_rst_n, (r_out_valid && r_out.body_valid) |-> (r_out.body_index < 8'(BODY_LEN)))

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ufr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_HOLD  = 4;
    localparam int PHASE_BYTES = 180;
    localparam int NUM_PHASES  = 6;

    typedef enum int {FRAME_GOOD, FRAME_BAD_A, FRAME_BAD_B} t_frame_kind;

    // byte-level model of the parser and the store of results still owed
    class frame_scoreboard;
        t_pos       pos;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        t_result    owed_q[$];
        int         errors;

        function new();
            pos         = POS_SYNC1;
            sum_a       = 8'h00;
            sum_b       = 8'h00;
            sync_first  = SYNC_FIRST_RST;
            sync_second = SYNC_SECOND_RST;
            errors      = 0;
        endfunction

        function void set_sync(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
            if (idx == CFG_SYNC_FIRST) begin
                sync_first = value;
            end else if (idx == CFG_SYNC_SECOND) begin
                sync_second = value;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // advance the parser by one received byte and queue its result word
        function void note_byte(logic [7:0] b);
            t_result r;
            r = '0;
            if (pos > POS_CKB) begin
                pos = POS_SYNC1;
            end
            if (pos == POS_SYNC1) begin
                pos = (b == sync_first) ? POS_SYNC2 : POS_SYNC1;
            end else if (pos == POS_SYNC2) begin
                if (b == sync_second) begin
                    sum_a = 8'h00;
                    sum_b = 8'h00;
                    pos   = POS_BODY0;
                end else begin
                    pos = POS_SYNC1;
                end
            end else if (pos < POS_CKA) begin
                r.body_valid = 1'b1;
                r.body_index = 8'(pos - POS_BODY0);
                r.body_byte  = b;
                sum_a        = sum_a + b;
                sum_b        = sum_b + sum_a;
                pos          = pos + t_pos'(1);
            end else if (pos == POS_CKA) begin
                if (b != sum_a) begin
                    r.frame_end = 1'b1;
                    pos         = POS_SYNC1;
                end else begin
                    pos = POS_CKB;
                end
            end else begin
                r.frame_end = 1'b1;
                r.frame_ok  = (b == sum_b);
                pos         = POS_SYNC1;
            end
            owed_q.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                report("result word with nothing owed");
            end else begin
                want = owed_q.pop_front();
                if (got.body_valid !== want.body_valid)
                    report($sformatf("body_valid got %b want %b",
                                     got.body_valid, want.body_valid));
                if (got.body_index !== want.body_index)
                    report($sformatf("body_index got %0d want %0d",
                                     got.body_index, want.body_index));
                if (got.body_byte !== want.body_byte)
                    report($sformatf("body_byte got %h want %h",
                                     got.body_byte, want.body_byte));
                if (got.frame_end !== want.frame_end)
                    report($sformatf("frame_end got %b want %b",
                                     got.frame_end, want.frame_end));
                if (got.frame_ok !== want.frame_ok)
                    report($sformatf("frame_ok got %b want %b",
                                     got.frame_ok, want.frame_ok));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ufr_rx_if  rx_if ();
    ufr_res_if res_if ();

    frame_scoreboard sb;

    int         src_idle;
    int         snk_idle;
    int         cycles;
    int         phase_bytes;
    logic [7:0] cur_first;
    logic [7:0] cur_second;

    ubx_frame_receiver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_if    (rx_if),
        .o_res_if   (res_if)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    // accepted input bytes go to the model
    always @(posedge i_clk) begin
        if (i_rst_n && rx_if.valid && rx_if.ready) begin
            sb.note_byte(rx_if.rx_byte);
        end
    end

    // accepted result words are checked against the oldest owed one
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.body_valid = res_if.body_valid;
            got.body_index = res_if.body_index;
            got.body_byte  = res_if.body_byte;
            got.frame_end  = res_if.frame_end;
            got.frame_ok   = res_if.frame_ok;
            sb.check_word(got);
        end
    end

    // offer one byte, idling at random first, and wait for the handshake
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        phase_bytes++;
    endtask

    // stop sending until every owed result has come out
    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_HOLD) @(posedge i_clk);
    endtask

    // write both preamble registers, block idle
    task automatic write_syncs(input logic [7:0] first, input logic [7:0] second);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SYNC_FIRST;
        i_cfg_data <= first;
        sb.set_sync(CFG_SYNC_FIRST, first);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SYNC_SECOND;
        i_cfg_data <= second;
        sb.set_sync(CFG_SYNC_SECOND, second);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cur_first  = first;
        cur_second = second;
    endtask

    // line noise between frames, now and then a broken preamble
    task automatic send_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 4);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) begin
                send_byte(cur_first);
                b = 8'($urandom_range(0, 255));
                if (b == cur_second) b = b ^ 8'h01;
                send_byte(b);
            end else begin
                b = 8'($urandom_range(0, 255));
                if (b == cur_first) b = b ^ 8'h01;
                send_byte(b);
            end
        end
    endtask

    // one whole frame; pause_at >= 0 drains the block mid-body
    task automatic send_frame(input t_frame_kind kind, input int pause_at);
        logic [7:0] b;
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        int         sel;
        ck_a = 8'h00;
        ck_b = 8'h00;
        send_byte(cur_first);
        send_byte(cur_second);
        for (int i = 0; i < BODY_LEN; i++) begin
            sel = $urandom_range(0, 7);
            if (sel == 0) b = 8'h00;
            else if (sel == 1) b = 8'hFF;
            else b = 8'($urandom_range(0, 255));
            ck_a = ck_a + b;
            ck_b = ck_b + ck_a;
            send_byte(b);
            if (i == pause_at) drain();
        end
        if (kind == FRAME_BAD_A) begin
            send_byte(ck_a ^ 8'($urandom_range(1, 255)));
        end else begin
            send_byte(ck_a);
            if (kind == FRAME_BAD_B) send_byte(ck_b ^ 8'($urandom_range(1, 255)));
            else send_byte(ck_b);
        end
    endtask

    // stimulus
    initial begin
        logic [7:0]  first_set [NUM_PHASES];
        logic [7:0]  second_set [NUM_PHASES];
        t_frame_kind kind;
        int          frame_no;
        int          pause_at;

        first_set  = '{SYNC_FIRST_RST, 8'h00, 8'hFF, 8'h5A, 8'hFF, 8'h00};
        second_set = '{SYNC_SECOND_RST, 8'hFF, 8'h00, 8'h5A, 8'hFF, 8'h00};

        sb            = new();
        cycles        = 0;
        src_idle      = 31;
        snk_idle      = 50;
        cur_first     = SYNC_FIRST_RST;
        cur_second    = SYNC_SECOND_RST;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_SYNC_FIRST;
        i_cfg_data    <= 8'h00;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, second-sync mismatch, mismatching byte not retested
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_FIRST_RST);
        send_byte(8'h00);
        send_byte(SYNC_SECOND_RST);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_SECOND_RST);
        send_byte(SYNC_FIRST_RST);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        drain();

        // random frames over several preamble settings and idle patterns
        frame_no = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 2) begin
                src_idle = 31;
                snk_idle = 50;
            end else if (p < 4) begin
                src_idle = 50;
                snk_idle = 31;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            if (p != 0) write_syncs(first_set[p], second_set[p]);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                send_noise();
                case (frame_no % 5)
                    1: begin
                        kind = FRAME_BAD_A;
                    end
                    3: begin
                        kind = FRAME_BAD_B;
                    end
                    default: begin
                        kind = FRAME_GOOD;
                    end
                endcase
                pause_at = (frame_no == 0) ? 40 : -1;
                send_frame(kind, pause_at);
                frame_no++;
            end
            send_noise();
            drain();
        end

        // final wait and verdict
        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
